>>> design/obstacle_clearance_point_adjust_unit_defines.svh
// Assertion macros shared by the obstacle clearance RTL.
`ifndef OBSTACLE_CLEARANCE_POINT_ADJUST_UNIT_DEFINES_SVH
`define OBSTACLE_CLEARANCE_POINT_ADJUST_UNIT_DEFINES_SVH

// Check a property outside of reset.
`define OCPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check a property at every edge, reset included.
`define OCPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/ocpa_pkg.sv
`timescale 1ns / 1ps

package ocpa_pkg;

  // Field and datapath widths
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned SAFE_W     = 15;
  localparam int unsigned MAG_W      = SAFE_W;        // |dx|, |dy| once below the radius
  localparam int unsigned PROD_W     = 2 * MAG_W;     // square or |d|*S
  localparam int unsigned D2_W       = 32;            // radicand shift register, even width
  localparam int unsigned ROOT_W     = D2_W / 2;
  localparam int unsigned SUB_W      = ROOT_W + 4;    // shared trial subtractor
  localparam int unsigned SQRT_STEPS = D2_W / 2;
  localparam int unsigned DIV_STEPS  = PROD_W;
  localparam int unsigned STEP_W     = 5;

  localparam logic [SAFE_W-1:0] SAFE_RESET = 15'd384;  // 1.5 m in Q7.8

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_ADD    = 2'd1,
    OP_ADJUST = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SSQ,
    ST_READ,
    ST_DIFF,
    ST_CHK,
    ST_MULX,
    ST_MULY,
    ST_SUM,
    ST_SQRT,
    ST_MDX,
    ST_DIVX,
    ST_MDY,
    ST_DIVY,
    ST_FIN
  } state_e;

  typedef struct packed {
    op_e                       opcode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] adjusted_x;
    logic signed [COORD_W-1:0] adjusted_y;
    logic                      was_moved;
  } out_t;

endpackage

>>> design/obstacle_clearance_point_adjust_unit.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Beat
// in        input      in_valid_i / in_stall_o    ocpa_pkg::in_t  (opcode, coord_x, coord_y)
// out       output     out_valid_o / out_stall_i  ocpa_pkg::out_t (adjusted_x/y, was_moved)
// cfg       input      cfg_we_i                   cfg_data_i (safe distance)
//
// Clear and add finish in idle. Adjust on an empty table goes straight to finish, else it
// squares the radius and scans each obstacle: read, diff, check (reject on |dx| or |dy|),
// then both squares and the sum (reject on distance). A hit runs the square root and both
// divisions a bit per cycle on one shared multiplier and one shared trial subtractor.
// Reset clears the obstacle count and sets the radius to 1.5 m; no clearing pass.
// A result waiting in the output register stalls only the next adjust, at its end.
`include "obstacle_clearance_point_adjust_unit_defines.svh"

module obstacle_clearance_point_adjust_unit #(
  parameter int unsigned MAX_OBSTACLES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ocpa_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ocpa_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [ocpa_pkg::SAFE_W-1:0]   cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_OBSTACLES + 1);
  localparam int unsigned IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBSTACLES);
  localparam int unsigned CW = ocpa_pkg::COORD_W;

  // Control registers
  ocpa_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]           count_q;
  logic [CNT_W-1:0]           idx_q;
  logic [ocpa_pkg::STEP_W-1:0] step_q;
  logic [ocpa_pkg::SAFE_W-1:0] safe_q;
  logic                       moved_q;
  logic                       out_valid_q;

  // Datapath registers
  logic [2*CW-1:0]                obs_mem [MAX_OBSTACLES];
  logic [2*CW-1:0]                rd_q;
  logic signed [CW-1:0]           px_q, py_q, ox_q, oy_q;
  logic signed [CW:0]             dx_q, dy_q;
  logic [ocpa_pkg::MAG_W-1:0]     adx_q, ady_q;
  logic [ocpa_pkg::PROD_W-1:0]    prod_q, acc_q, ss_q, dvd_q;
  logic [ocpa_pkg::D2_W-1:0]      d2_q;
  logic [ocpa_pkg::SUB_W-1:0]     rem_q;
  logic [ocpa_pkg::ROOT_W-1:0]    root_q;
  logic signed [CW:0]             qx_q;
  ocpa_pkg::out_t                 out_q;

  // Combinational signals
  logic                           in_accept;
  logic                           mem_we;
  logic [ocpa_pkg::MAG_W-1:0]     mul_a, mul_b;
  logic [ocpa_pkg::PROD_W-1:0]    mul_p;
  logic [ocpa_pkg::SUB_W-1:0]     sub_a, sub_b;
  logic [ocpa_pkg::SUB_W:0]       sub_diff;
  logic                           sub_ge;
  logic [CW:0]                    adx_full, ady_full;
  logic                           chk_far;
  logic [ocpa_pkg::PROD_W:0]      d2_sum;
  logic                           sum_far, sum_zero;
  logic [CNT_W-1:0]               idx_next;
  logic                           scan_end;
  logic                           step_last_sqrt, step_last_div;
  logic                           out_free;
  logic signed [CW:0]             qx_now, qy_now;
  logic signed [CW+1:0]           sum_x, sum_y;
  logic signed [CW-1:0]           sat_x, sat_y;
  logic [ocpa_pkg::SUB_W-1:0]     sq_rem_sh, dv_rem_sh;

  assign in_stall_o  = (state_q != ocpa_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Distance checks on the fetched obstacle
  assign adx_full = dx_q[CW] ? (CW+1)'(-dx_q) : dx_q;
  assign ady_full = dy_q[CW] ? (CW+1)'(-dy_q) : dy_q;
  assign chk_far  = (adx_full >= (CW+1)'(safe_q)) || (ady_full >= (CW+1)'(safe_q));
  assign d2_sum   = {1'b0, acc_q} + {1'b0, prod_q};
  assign sum_far  = (d2_sum >= {1'b0, ss_q});
  assign sum_zero = (d2_sum == '0);
  assign idx_next = idx_q + 1'b1;
  assign scan_end = (idx_next == count_q);

  assign step_last_sqrt = (step_q == ocpa_pkg::STEP_W'(ocpa_pkg::SQRT_STEPS - 1));
  assign step_last_div  = (step_q == ocpa_pkg::STEP_W'(ocpa_pkg::DIV_STEPS - 1));

  // Shared multiplier and trial subtractor
  assign mul_p    = mul_a * mul_b;
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[ocpa_pkg::SUB_W];

  assign sq_rem_sh = {rem_q[ocpa_pkg::SUB_W-3:0], d2_q[ocpa_pkg::D2_W-1 -: 2]};
  assign dv_rem_sh = {rem_q[ocpa_pkg::SUB_W-2:0], dvd_q[ocpa_pkg::PROD_W-1]};

  // Signed quotient: magnitude stays below the radius, so the low bits suffice
  assign qx_now = dx_q[CW] ? -$signed({1'b0, dvd_q[CW-1:0]}) : $signed({1'b0, dvd_q[CW-1:0]});
  assign qy_now = dy_q[CW] ? -$signed({1'b0, dvd_q[CW-1:0]}) : $signed({1'b0, dvd_q[CW-1:0]});

  // Final sums with saturation
  assign sum_x = (CW+2)'(ox_q) + (CW+2)'(qx_q);
  assign sum_y = (CW+2)'(oy_q) + (CW+2)'(qy_now);

  always_comb begin
    sat_x = sum_x[CW-1:0];
    if (sum_x > (CW+2)'($signed({1'b0, {(CW-1){1'b1}}}))) begin
      sat_x = {1'b0, {(CW-1){1'b1}}};
    end else if (sum_x < -(CW+2)'($signed({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
      sat_x = {1'b1, {(CW-1){1'b0}}};
    end
  end

  always_comb begin
    sat_y = sum_y[CW-1:0];
    if (sum_y > (CW+2)'($signed({1'b0, {(CW-1){1'b1}}}))) begin
      sat_y = {1'b0, {(CW-1){1'b1}}};
    end else if (sum_y < -(CW+2)'($signed({1'b0, 1'b1, {(CW-1){1'b0}}}))) begin
      sat_y = {1'b1, {(CW-1){1'b0}}};
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ocpa_pkg::ST_IDLE: begin
        if (in_accept && in_data_i.opcode == ocpa_pkg::OP_ADJUST) begin
          state_d = (count_q == '0) ? ocpa_pkg::ST_FIN : ocpa_pkg::ST_SSQ;
        end
      end
      ocpa_pkg::ST_SSQ:  state_d = ocpa_pkg::ST_READ;
      ocpa_pkg::ST_READ: state_d = ocpa_pkg::ST_DIFF;
      ocpa_pkg::ST_DIFF: state_d = ocpa_pkg::ST_CHK;
      ocpa_pkg::ST_CHK: begin
        if (!chk_far) begin
          state_d = ocpa_pkg::ST_MULX;
        end else begin
          state_d = scan_end ? ocpa_pkg::ST_FIN : ocpa_pkg::ST_READ;
        end
      end
      ocpa_pkg::ST_MULX: state_d = ocpa_pkg::ST_MULY;
      ocpa_pkg::ST_MULY: state_d = ocpa_pkg::ST_SUM;
      ocpa_pkg::ST_SUM: begin
        if (sum_far) begin
          state_d = scan_end ? ocpa_pkg::ST_FIN : ocpa_pkg::ST_READ;
        end else if (sum_zero) begin
          state_d = ocpa_pkg::ST_FIN;
        end else begin
          state_d = ocpa_pkg::ST_SQRT;
        end
      end
      ocpa_pkg::ST_SQRT: if (step_last_sqrt) state_d = ocpa_pkg::ST_MDX;
      ocpa_pkg::ST_MDX:  state_d = ocpa_pkg::ST_DIVX;
      ocpa_pkg::ST_DIVX: if (step_last_div) state_d = ocpa_pkg::ST_MDY;
      ocpa_pkg::ST_MDY:  state_d = ocpa_pkg::ST_DIVY;
      ocpa_pkg::ST_DIVY: if (step_last_div) state_d = ocpa_pkg::ST_FIN;
      ocpa_pkg::ST_FIN:  if (out_free) state_d = ocpa_pkg::ST_IDLE;
      default:           state_d = ocpa_pkg::ST_IDLE;
    endcase
  end

  // Unit operand selection and table write
  always_comb begin
    mem_we = 1'b0;
    mul_a  = adx_q;
    mul_b  = adx_q;
    sub_a  = sq_rem_sh;
    sub_b  = ocpa_pkg::SUB_W'({root_q, 2'b01});
    unique case (state_q)
      ocpa_pkg::ST_IDLE: begin
        mem_we = in_accept && (in_data_i.opcode == ocpa_pkg::OP_ADD) && (count_q != MAX_CNT);
      end
      ocpa_pkg::ST_SSQ: begin
        mul_a = safe_q;
        mul_b = safe_q;
      end
      ocpa_pkg::ST_MULY: begin
        mul_a = ady_q;
        mul_b = ady_q;
      end
      ocpa_pkg::ST_MDX: begin
        mul_a = adx_q;
        mul_b = safe_q;
      end
      ocpa_pkg::ST_MDY: begin
        mul_a = ady_q;
        mul_b = safe_q;
      end
      ocpa_pkg::ST_DIVX, ocpa_pkg::ST_DIVY: begin
        sub_a = dv_rem_sh;
        sub_b = ocpa_pkg::SUB_W'(root_q);
      end
      default: begin
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ocpa_pkg::ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      safe_q      <= ocpa_pkg::SAFE_RESET;
      moved_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        safe_q <= cfg_data_i;
      end
      if (in_accept) begin
        case (in_data_i.opcode)
          ocpa_pkg::OP_CLEAR: count_q <= '0;
          ocpa_pkg::OP_ADD:   if (count_q != MAX_CNT) count_q <= count_q + 1'b1;
          ocpa_pkg::OP_ADJUST: begin
            idx_q   <= '0;
            moved_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      // Advance to the next obstacle on a miss
      if ((state_q == ocpa_pkg::ST_CHK && chk_far) ||
          (state_q == ocpa_pkg::ST_SUM && sum_far)) begin
        idx_q <= idx_next;
      end
      if (state_q == ocpa_pkg::ST_SUM && !sum_far && !sum_zero) begin
        moved_q <= 1'b1;
      end
      // Step counter for the root and both divisions
      if (state_q == ocpa_pkg::ST_SQRT || state_q == ocpa_pkg::ST_DIVX ||
          state_q == ocpa_pkg::ST_DIVY) begin
        step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
      end else begin
        step_q <= '0;
      end
      // Output register handshake
      if (state_q == ocpa_pkg::ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Obstacle table, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      obs_mem[count_q[IDX_W-1:0]] <= {in_data_i.coord_x, in_data_i.coord_y};
    end
    rd_q <= obs_mem[idx_q[IDX_W-1:0]];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ocpa_pkg::ST_IDLE: begin
        px_q <= in_data_i.coord_x;
        py_q <= in_data_i.coord_y;
        if (in_accept) begin
          // hold the query point
        end
      end
      ocpa_pkg::ST_SSQ: ss_q <= mul_p;
      ocpa_pkg::ST_DIFF: begin
        ox_q <= rd_q[2*CW-1:CW];
        oy_q <= rd_q[CW-1:0];
        dx_q <= (CW+1)'(px_q) - (CW+1)'($signed(rd_q[2*CW-1:CW]));
        dy_q <= (CW+1)'(py_q) - (CW+1)'($signed(rd_q[CW-1:0]));
      end
      ocpa_pkg::ST_CHK: begin
        adx_q <= adx_full[ocpa_pkg::MAG_W-1:0];
        ady_q <= ady_full[ocpa_pkg::MAG_W-1:0];
      end
      ocpa_pkg::ST_MULX: prod_q <= mul_p;
      ocpa_pkg::ST_MULY: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      ocpa_pkg::ST_SUM: begin
        d2_q   <= ocpa_pkg::D2_W'(d2_sum);
        rem_q  <= '0;
        root_q <= '0;
      end
      // One radicand digit pair per cycle
      ocpa_pkg::ST_SQRT: begin
        d2_q <= {d2_q[ocpa_pkg::D2_W-3:0], 2'b00};
        if (sub_ge) begin
          rem_q  <= sub_diff[ocpa_pkg::SUB_W-1:0];
          root_q <= {root_q[ocpa_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= sq_rem_sh;
          root_q <= {root_q[ocpa_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      ocpa_pkg::ST_MDX: begin
        dvd_q <= mul_p;
        rem_q <= '0;
      end
      ocpa_pkg::ST_MDY: begin
        qx_q  <= qx_now;
        dvd_q <= mul_p;
        rem_q <= '0;
      end
      // One quotient bit per cycle
      ocpa_pkg::ST_DIVX, ocpa_pkg::ST_DIVY: begin
        rem_q <= sub_ge ? sub_diff[ocpa_pkg::SUB_W-1:0] : dv_rem_sh;
        dvd_q <= {dvd_q[ocpa_pkg::PROD_W-2:0], sub_ge};
      end
      ocpa_pkg::ST_FIN: begin
        if (out_free) begin
          out_q.adjusted_x <= moved_q ? sat_x : px_q;
          out_q.adjusted_y <= moved_q ? sat_y : py_q;
          out_q.was_moved  <= moved_q;
        end
      end
      default: begin
      end
    endcase
  end

  `OCPA_ASSERT_ALWAYS(a_count_bound, !rst_ni || count_q <= MAX_CNT, "count above capacity")
  `OCPA_ASSERT(a_add_count, mem_we |=> (count_q == $past(count_q) + 1'b1), "add did not count")
  `OCPA_ASSERT(a_out_from_fin, $rose(out_valid_q) |-> $past(state_q == ocpa_pkg::ST_FIN),
               "result beat without a finished query")
  `OCPA_ASSERT(a_fin_hold,
               (state_q == ocpa_pkg::ST_FIN && out_valid_q && out_stall_i) |=>
               (state_q == ocpa_pkg::ST_FIN), "query left finish while output blocked")

endmodule
